// ===== rtl/kstu_pkg.sv =====
// Shared types and constants for the keypad scanner with serial transmitter.
package kstu_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	localparam int unsigned PERIOD_W = 9;
	localparam logic [PERIOD_W-1:0] PERIOD_MAX = 9'd256;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 9'd256;

	localparam int unsigned KEY_W = 6;
	localparam logic [KEY_W-1:0] KEY_NONE = 6'd0;
	localparam logic [KEY_W-1:0] KEY_1 = 6'd49;
	localparam logic [KEY_W-1:0] KEY_2 = 6'd50;
	localparam logic [KEY_W-1:0] KEY_3 = 6'd51;
	localparam logic [KEY_W-1:0] KEY_4 = 6'd52;
	localparam logic [KEY_W-1:0] KEY_5 = 6'd53;
	localparam logic [KEY_W-1:0] KEY_6 = 6'd54;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	localparam logic [3:0] FRAME_BITS = 4'd10;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_A = 2'd1;
	localparam logic [1:0] PH_B = 2'd2;

	typedef struct packed {
		logic             put;
		logic [KEY_W-1:0] key;
	} kstu_put_t;

endpackage

// ===== rtl/kstu_fifo.sv =====
// Transmit queue taking key, CR and LF in one beat as space allows; one byte out per pop.
module kstu_fifo #(
	parameter int unsigned QUEUE_DEPTH = kstu_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              pop,
	input  kstu_pkg::kstu_put_t put,
	output logic              nonempty,
	output logic [7:0]        head,
	output logic [2:0]        level_nxt
);
	import kstu_pkg::*;

	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned SLOT_W = $clog2(QUEUE_DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_DEPTH - 1);

	logic [7:0]        mem_q [QUEUE_DEPTH];
	logic [SLOT_W-1:0] rd_q, wr_q;
	logic [CNT_W-1:0]  count_q;

	logic              pop_ok;
	logic [CNT_W-1:0]  count_mid, free_slots, count_nxt;
	logic [1:0]        take;
	logic [SLOT_W-1:0] w1, w2, wr_nxt, rd_nxt;

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
		return (s == LAST_SLOT) ? '0 : s + 1'b1;
	endfunction

	assign nonempty = (count_q != '0);
	assign head = mem_q[rd_q];
	assign pop_ok = pop && nonempty;
	assign count_mid = count_q - CNT_W'(pop_ok);
	assign free_slots = DEPTH_C - count_mid;

	always_comb begin
		if (!put.put) begin
			take = 2'd0;
		end else if (free_slots >= CNT_W'(3)) begin
			take = 2'd3;
		end else begin
			take = 2'(free_slots);
		end
	end

	assign w1 = slot_inc(wr_q);
	assign w2 = slot_inc(w1);
	assign count_nxt = count_mid + CNT_W'(take);
	assign level_nxt = 3'(count_nxt);
	assign rd_nxt = pop_ok ? slot_inc(rd_q) : rd_q;

	always_comb begin
		case (take)
			2'd1: wr_nxt = w1;
			2'd2: wr_nxt = w2;
			2'd3: wr_nxt = slot_inc(w2);
			default: wr_nxt = wr_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (take > 2'd0) mem_q[wr_q] <= {2'b00, put.key};
			if (take > 2'd1) mem_q[w1] <= CHAR_CR;
			if (take > 2'd2) mem_q[w2] <= CHAR_LF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			wr_q <= '0;
			count_q <= '0;
		end else if (adv) begin
			rd_q <= rd_nxt;
			wr_q <= wr_nxt;
			count_q <= count_nxt;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("queue count exceeds depth");

	a_slots_meet: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == DEPTH_C) |-> (wr_q == rd_q))
		else $error("queue slots disagree with count");
`endif

endmodule

// ===== rtl/kstu_serial.sv =====
// Serial 8N1 frame shifter, one bit per beat, loading the next byte as a frame ends.
module kstu_serial (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic       nonempty,
	input  logic [7:0] head,
	output logic       pop,
	output logic       line_nxt
);
	import kstu_pkg::*;

	logic [9:0] frame_q, frame_mid, frame_nxt;
	logic [3:0] bits_q, bits_mid, bits_nxt;
	logic       line_q;

	always_comb begin
		if (bits_q != 4'd0) begin
			bits_mid = bits_q - 4'd1;
			line_nxt = frame_q[0];
			frame_mid = frame_q >> 1;
		end else begin
			bits_mid = bits_q;
			line_nxt = line_q;
			frame_mid = frame_q;
		end
	end

	assign pop = (bits_mid == 4'd0) && nonempty;
	assign frame_nxt = pop ? {1'b1, head, 1'b0} : frame_mid;
	assign bits_nxt = pop ? FRAME_BITS : bits_mid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			bits_q <= '0;
			line_q <= 1'b1;
		end else if (adv) begin
			frame_q <= frame_nxt;
			bits_q <= bits_nxt;
			line_q <= line_nxt;
		end
	end

`ifndef SYNTHESIS
	a_bits_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bits_q <= FRAME_BITS)
		else $error("frame bit count out of range");
`endif

endmodule

// ===== rtl/kstu_keypad.sv =====
// Keypad scan sequencer and key decoder.
module kstu_keypad (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic                            line_a_level,
	input  logic                            line_b_level,
	input  logic                            line_c_level,
	input  logic [kstu_pkg::PERIOD_W-1:0]   scan_period,
	output kstu_pkg::kstu_put_t             put,
	output logic [1:0]                      phase_nxt,
	output logic [kstu_pkg::KEY_W-1:0]      last_nxt
);
	import kstu_pkg::*;

	logic [7:0]          period_q, period_nxt;
	logic [1:0]          phase_q;
	logic [KEY_W-1:0]    last_q;

	logic [PERIOD_W-1:0] limit, count_inc;
	logic                finish;
	logic [KEY_W-1:0]    key;

	assign limit = (scan_period > PERIOD_MAX) ? PERIOD_MAX : scan_period;
	assign count_inc = {1'b0, period_q} + 9'd1;

	always_comb begin
		finish = 1'b0;
		key = KEY_NONE;
		phase_nxt = phase_q;
		period_nxt = period_q;
		last_nxt = last_q;
		put.put = 1'b0;
		put.key = KEY_NONE;
		case (phase_q)
			PH_A: begin
				if (!line_b_level) begin
					finish = 1'b1;
					key = KEY_5;
				end else if (!line_c_level) begin
					finish = 1'b1;
					key = KEY_6;
				end else begin
					phase_nxt = PH_B;
				end
			end
			PH_B: begin
				finish = 1'b1;
				key = line_c_level ? KEY_NONE : KEY_4;
			end
			default: begin
				period_nxt = (count_inc >= limit) ? 8'd0 : count_inc[7:0];
				if (period_q == 8'd0) begin
					if (!line_a_level) begin
						finish = 1'b1;
						key = KEY_3;
					end else if (!line_b_level) begin
						finish = 1'b1;
						key = KEY_2;
					end else if (!line_c_level) begin
						finish = 1'b1;
						key = KEY_1;
					end else begin
						phase_nxt = PH_A;
					end
				end
			end
		endcase
		if (finish) begin
			phase_nxt = PH_IDLE;
			if (key != last_q) begin
				last_nxt = key;
				put.put = (key != KEY_NONE);
				put.key = key;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= '0;
			phase_q <= PH_IDLE;
			last_q <= KEY_NONE;
		end else if (adv) begin
			period_q <= period_nxt;
			phase_q <= phase_nxt;
			last_q <= last_nxt;
		end
	end

endmodule

// ===== rtl/keypad_scan_to_uart_tx_top.sv =====
// Top level of the keypad scanner feeding an 8N1 serial transmitter.
//
//   Channel  Direction  Handshake               Content
//   in       input      in_valid / in_stall     line_a_level, line_b_level, line_c_level
//   out      output     out_valid / out_stall   serial_line, drive_a_low, drive_b_low,
//                                               queue_level, current_key
//   cfg      input      cfg_valid / cfg_ready   cfg_data (scan period)
//
// Each input beat is one bit-time tick and yields one registered output beat.
// A new beat is taken every cycle while the output register is empty or being drained.
// The output register holds its beat while out_stall is high; in_stall follows it.
// Reset clears all control state; the scan period resets to 256 and the line idles high.
// Configuration writes are always ready and take effect on the next tick.
module keypad_scan_to_uart_tx_top #(
	parameter int unsigned QUEUE_DEPTH = kstu_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           line_a_level,
	input  logic                           line_b_level,
	input  logic                           line_c_level,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           serial_line,
	output logic                           drive_a_low,
	output logic                           drive_b_low,
	output logic [2:0]                     queue_level,
	output logic [kstu_pkg::KEY_W-1:0]     current_key,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [kstu_pkg::PERIOD_W-1:0]  cfg_data
);
	import kstu_pkg::*;

	logic                adv;
	logic                out_valid_q;
	logic [PERIOD_W-1:0] scan_period_q;

	logic                serial_line_q, drive_a_low_q, drive_b_low_q;
	logic [2:0]          queue_level_q;
	logic [KEY_W-1:0]    current_key_q;

	kstu_put_t           put;
	logic                pop, nonempty, line_nxt;
	logic [7:0]          head;
	logic [2:0]          level_nxt;
	logic [1:0]          phase_nxt;
	logic [KEY_W-1:0]    last_nxt;

	assign in_stall = out_valid_q && out_stall;
	assign adv = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	kstu_serial u_serial (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.nonempty (nonempty),
		.head     (head),
		.pop      (pop),
		.line_nxt (line_nxt)
	);

	kstu_fifo #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.pop       (pop),
		.put       (put),
		.nonempty  (nonempty),
		.head      (head),
		.level_nxt (level_nxt)
	);

	kstu_keypad u_keypad (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.line_a_level (line_a_level),
		.line_b_level (line_b_level),
		.line_c_level (line_c_level),
		.scan_period  (scan_period_q),
		.put          (put),
		.phase_nxt    (phase_nxt),
		.last_nxt     (last_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_period_q <= PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			scan_period_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			serial_line_q <= line_nxt;
			drive_a_low_q <= (phase_nxt == PH_A);
			drive_b_low_q <= (phase_nxt == PH_B);
			queue_level_q <= level_nxt;
			current_key_q <= last_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign serial_line = serial_line_q;
	assign drive_a_low = drive_a_low_q;
	assign drive_b_low = drive_b_low_q;
	assign queue_level = queue_level_q;
	assign current_key = current_key_q;

`ifndef SYNTHESIS
	a_result_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(in_valid))
		else $error("result beat appeared without a tick");

	a_one_line_driven: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(drive_a_low_q && drive_b_low_q))
		else $error("both scan lines driven at once");
`endif

endmodule
